// ----- rtl/core/assert_macros.svh -----
// Assertion helpers used by the checker file mexp_check.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/core/mexp_pkg.sv -----
`timescale 1ns / 1ps

package mexp_pkg;

    localparam int OPERAND_BITS_DEF = 32;
    localparam int FIELD_BITS       = 32;
    localparam logic [FIELD_BITS-1:0] MODULUS_RESET = 32'd1;

    // Microcode step address
    typedef logic [3:0] upc_t;

    localparam upc_t PC_WAIT     = 4'd0;
    localparam upc_t PC_ZCHK     = 4'd1;
    localparam upc_t PC_RED_GO   = 4'd2;
    localparam upc_t PC_RED_WAIT = 4'd3;
    localparam upc_t PC_INIT     = 4'd4;
    localparam upc_t PC_SQ_GO    = 4'd5;
    localparam upc_t PC_SQ_WAIT  = 4'd6;
    localparam upc_t PC_BIT      = 4'd7;
    localparam upc_t PC_MB_GO    = 4'd8;
    localparam upc_t PC_MB_WAIT  = 4'd9;
    localparam upc_t PC_NEXT     = 4'd10;
    localparam upc_t PC_LOOP     = 4'd11;
    localparam upc_t PC_ONE      = 4'd12;
    localparam upc_t PC_OUT      = 4'd13;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,     // capture base/exponent on request acceptance
        OP_MUL_B1,   // start b * 1 (reduces base)
        OP_WR_B,     // b <= product when done
        OP_SET_R1,   // r <= 1
        OP_MUL_RR,   // start r * r
        OP_WR_R,     // r <= product when done
        OP_MUL_RB,   // start r * b
        OP_DEC_IDX,  // step to next exponent bit
        OP_EMIT      // move r to output register when free
    } uop_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_IN,
        C_EZERO,
        C_EBIT0,
        C_DONE,
        C_IDX0,
        C_OUT_FREE
    } cond_t;

    // On cond true jump to target; otherwise hold in place or fall through.
    typedef struct packed {
        uop_t  op;
        cond_t cond;
        logic  hold;
        upc_t  target;
    } uword_t;

    function automatic uword_t ucode(input upc_t pc);
        uword_t w;
        case (pc)
            PC_WAIT:     w = '{op: OP_LOAD,    cond: C_IN,       hold: 1'b1, target: PC_ZCHK};
            PC_ZCHK:     w = '{op: OP_NONE,    cond: C_EZERO,    hold: 1'b0, target: PC_ONE};
            PC_RED_GO:   w = '{op: OP_MUL_B1,  cond: C_NEVER,    hold: 1'b0, target: PC_WAIT};
            PC_RED_WAIT: w = '{op: OP_WR_B,    cond: C_DONE,     hold: 1'b1, target: PC_INIT};
            PC_INIT:     w = '{op: OP_SET_R1,  cond: C_NEVER,    hold: 1'b0, target: PC_WAIT};
            PC_SQ_GO:    w = '{op: OP_MUL_RR,  cond: C_NEVER,    hold: 1'b0, target: PC_WAIT};
            PC_SQ_WAIT:  w = '{op: OP_WR_R,    cond: C_DONE,     hold: 1'b1, target: PC_BIT};
            PC_BIT:      w = '{op: OP_NONE,    cond: C_EBIT0,    hold: 1'b0, target: PC_NEXT};
            PC_MB_GO:    w = '{op: OP_MUL_RB,  cond: C_NEVER,    hold: 1'b0, target: PC_WAIT};
            PC_MB_WAIT:  w = '{op: OP_WR_R,    cond: C_DONE,     hold: 1'b1, target: PC_NEXT};
            PC_NEXT:     w = '{op: OP_DEC_IDX, cond: C_IDX0,     hold: 1'b0, target: PC_OUT};
            PC_LOOP:     w = '{op: OP_NONE,    cond: C_ALWAYS,   hold: 1'b0, target: PC_SQ_GO};
            PC_ONE:      w = '{op: OP_SET_R1,  cond: C_ALWAYS,   hold: 1'b0, target: PC_OUT};
            PC_OUT:      w = '{op: OP_EMIT,    cond: C_OUT_FREE, hold: 1'b1, target: PC_WAIT};
            default:     w = '{op: OP_NONE,    cond: C_ALWAYS,   hold: 1'b0, target: PC_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/core/mexp_mul.sv -----
`timescale 1ns / 1ps

// Interleaved modular multiplier: one multiplier bit per cycle, MSB first.
// Needs y <= m. A zero modulus wraps at the operand width.
module mexp_mul #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] x,
    input  logic [W-1:0] y,
    input  logic [W-1:0] m,
    output logic         done,
    output logic [W-1:0] prod
);
    import mexp_pkg::*;

    localparam int CW = (W > 1) ? $clog2(W) : 1;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  xs_reg, xs_next;
    logic [W-1:0]  y_reg, y_next;

    logic [W+1:0]  sum;
    logic [W+1:0]  d1;
    logic [W+1:0]  d2;
    logic [W-1:0]  step_val;

    always_comb
    begin
        sum = {1'b0, acc_reg, 1'b0} + (xs_reg[W-1] ? {2'b00, y_reg} : '0);
        d1  = sum - {2'b00, m};
        d2  = sum - {1'b0, m, 1'b0};
        // sum < 3m, so at most one of the two subtractions is taken
        if (m == '0)
            step_val = sum[W-1:0];
        else if (!d2[W+1])
            step_val = d2[W-1:0];
        else if (!d1[W+1])
            step_val = d1[W-1:0];
        else
            step_val = sum[W-1:0];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        xs_next   = xs_reg;
        y_next    = y_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(W - 1);
            acc_next  = '0;
            xs_next   = x;
            y_next    = y;
        end
        else if (busy_reg)
        begin
            acc_next = step_val;
            xs_next  = {xs_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        xs_reg  <= xs_next;
        y_reg   <= y_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ----- rtl/core/mexp_seq.sv -----
`timescale 1ns / 1ps

// Microcode sequencer with the exponent/result datapath and output register.
module mexp_seq #(
    parameter int W = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [W-1:0]                   base_w,
    input  logic [W-1:0]                   exp_w,
    output logic                           mul_start,
    output logic [W-1:0]                   mul_x,
    output logic [W-1:0]                   mul_y,
    input  logic                           mul_done,
    input  logic [W-1:0]                   mul_prod,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [mexp_pkg::FIELD_BITS-1:0] power_result
);
    import mexp_pkg::*;

    localparam int IW = (W > 1) ? $clog2(W) : 1;

    upc_t          pc_reg, pc_next;
    logic [W-1:0]  b_reg, b_next;
    logic [W-1:0]  e_reg, e_next;
    logic [W-1:0]  r_reg, r_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          ov_reg, ov_next;
    logic [FIELD_BITS-1:0] res_reg, res_next;

    uword_t        w;
    logic          cond_ok;
    logic          out_free;

    assign out_free = !ov_reg || !out_stall;

    always_comb
    begin
        w = ucode(pc_reg);
        case (w.cond)
            C_NEVER:    cond_ok = 1'b0;
            C_ALWAYS:   cond_ok = 1'b1;
            C_IN:       cond_ok = in_valid;
            C_EZERO:    cond_ok = (e_reg == '0);
            C_EBIT0:    cond_ok = !e_reg[idx_reg];
            C_DONE:     cond_ok = mul_done;
            C_IDX0:     cond_ok = (idx_reg == '0);
            C_OUT_FREE: cond_ok = out_free;
            default:    cond_ok = 1'b0;
        endcase

        if (cond_ok)
            pc_next = w.target;
        else if (w.hold)
            pc_next = pc_reg;
        else
            pc_next = pc_reg + 1'b1;

        b_next   = b_reg;
        e_next   = e_reg;
        r_next   = r_reg;
        idx_next = idx_reg;
        res_next = res_reg;
        ov_next  = ov_reg && out_stall;
        mul_start = (w.op inside {OP_MUL_B1, OP_MUL_RR, OP_MUL_RB});
        mul_x     = (w.op == OP_MUL_B1) ? b_reg : r_reg;
        mul_y     = r_reg;

        case (w.op)
            OP_LOAD:
            begin
                if (in_valid)
                begin
                    b_next   = base_w;
                    e_next   = exp_w;
                    idx_next = IW'(W - 1);
                end
            end
            OP_MUL_B1:  mul_y = W'(1);
            OP_WR_B:    if (mul_done) b_next = mul_prod;
            OP_SET_R1:  r_next = W'(1);
            OP_MUL_RR:  mul_y = r_reg;
            OP_WR_R:    if (mul_done) r_next = mul_prod;
            OP_MUL_RB:  mul_y = b_reg;
            OP_DEC_IDX: idx_next = idx_reg - 1'b1;
            OP_EMIT:
            begin
                if (out_free)
                begin
                    res_next = FIELD_BITS'(r_reg);
                    ov_next  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_WAIT;
            ov_reg <= 1'b0;
        end
        else
        begin
            pc_reg <= pc_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg   <= b_next;
        e_reg   <= e_next;
        r_reg   <= r_next;
        idx_reg <= idx_next;
        res_reg <= res_next;
    end

    assign in_stall     = (pc_reg != PC_WAIT);
    assign out_valid    = ov_reg;
    assign power_result = res_reg;

endmodule

// ----- rtl/core/modular_exponentiation.sv -----
`timescale 1ns / 1ps

// Channel   Handshake            Payload
// -------   ------------------   ----------------------
// in        in_valid / in_stall  base, exponent
// out       out_valid/out_stall  power_result
// cfg       cfg_valid/cfg_ready  modulus
//
// One request at a time. Each modular product takes a start step, one
// multiplier bit per cycle and a write-back step. A request runs a base
// reduction, one squaring per exponent bit and one more product for each set
// exponent bit; a zero exponent runs no product.
// Reset puts the sequencer at its wait step and sets the modulus to 1.
// A stalled result sits in the output register while the next request runs.
module modular_exponentiation #(
    parameter int OPERAND_BITS = mexp_pkg::OPERAND_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [mexp_pkg::FIELD_BITS-1:0] base,
    input  logic [mexp_pkg::FIELD_BITS-1:0] exponent,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [mexp_pkg::FIELD_BITS-1:0] power_result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mexp_pkg::FIELD_BITS-1:0] modulus
);
    import mexp_pkg::*;

    localparam int W = OPERAND_BITS;

    logic [FIELD_BITS-1:0] mod_reg, mod_next;
    logic                  mul_start;
    logic                  mul_done;
    logic [W-1:0]          mul_x;
    logic [W-1:0]          mul_y;
    logic [W-1:0]          mul_prod;

    assign cfg_ready = 1'b1;
    assign mod_next  = (cfg_valid && cfg_ready) ? modulus : mod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mod_reg <= MODULUS_RESET;
        else
            mod_reg <= mod_next;
    end

    mexp_seq #(
        .W(W)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .base_w       (base[W-1:0]),
        .exp_w        (exponent[W-1:0]),
        .mul_start    (mul_start),
        .mul_x        (mul_x),
        .mul_y        (mul_y),
        .mul_done     (mul_done),
        .mul_prod     (mul_prod),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .power_result (power_result)
    );

    mexp_mul #(
        .W(W)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .x     (mul_x),
        .y     (mul_y),
        .m     (mod_reg[W-1:0]),
        .done  (mul_done),
        .prod  (mul_prod)
    );

endmodule

// ----- rtl/core/mexp_check.sv -----
`timescale 1ns / 1ps

`include "assert_macros.svh"

module mexp_check (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [mexp_pkg::FIELD_BITS-1:0] power_result,
    input logic                            cfg_valid,
    input logic                            cfg_ready
);
    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(power_result))
    // one request in flight: accepting closes the input
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
    // a new result comes only after the input has been closed
    `ASSERT_IMPLY(a_result_latency, clk, rst_n, $rose(out_valid), $past(in_stall, 2))
    // the modulus register takes a write at any time
    `ASSERT_IMPLY(a_cfg_always_ready, clk, rst_n, cfg_valid, cfg_ready)

endmodule

bind modular_exponentiation mexp_check u_mexp_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .power_result (power_result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready)
);

// ----- dv/power_checker.sv -----
`timescale 1ns / 1ps

module power_checker #(
    parameter int OPERAND_BITS = mexp_pkg::OPERAND_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [mexp_pkg::FIELD_BITS-1:0] base,
    input  logic [mexp_pkg::FIELD_BITS-1:0] exponent,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [mexp_pkg::FIELD_BITS-1:0] power_result,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [mexp_pkg::FIELD_BITS-1:0] modulus,
    output int                              mismatches,
    output int                              backlog,
    output int                              results_seen
);
    import mexp_pkg::*;

    localparam logic [63:0] OPERAND_MASK = (64'd1 << OPERAND_BITS) - 64'd1;

    logic [FIELD_BITS-1:0] modulus_shadow;
    logic [FIELD_BITS-1:0] expected_powers[$];

    // modulus of zero: product wraps at the operand width
    function automatic logic [63:0] mul_mod(input logic [63:0] x, input logic [63:0] y,
                                            input logic [63:0] m);
        logic [63:0] p;
        p = x * y;
        if (m == 64'd0)
            return p & OPERAND_MASK;
        return p % m;
    endfunction

    function automatic logic [FIELD_BITS-1:0] predict_power(
        input logic [FIELD_BITS-1:0] b_in,
        input logic [FIELD_BITS-1:0] e_in,
        input logic [FIELD_BITS-1:0] m_in
    );
        logic [63:0] m;
        logic [63:0] b;
        logic [63:0] e;
        logic [63:0] acc;
        m = 64'(m_in) & OPERAND_MASK;
        b = 64'(b_in) & OPERAND_MASK;
        e = 64'(e_in) & OPERAND_MASK;
        // zero exponent gives 1, never reduced
        if (e == 64'd0)
            return FIELD_BITS'(1);
        if (m != 64'd0)
            b = b % m;
        acc = 64'd1;
        for (int i = OPERAND_BITS - 1; i >= 0; i--)
        begin
            acc = mul_mod(acc, acc, m);
            if (e[i])
                acc = mul_mod(acc, b, m);
        end
        return acc[FIELD_BITS-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_shadow <= MODULUS_RESET;
            backlog        <= 0;
            results_seen   <= 0;
            expected_powers.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                modulus_shadow <= modulus;
            // retire before queuing so a same-edge request cannot mask a stray result
            if (out_valid && !out_stall)
            begin
                results_seen <= results_seen + 1;
                if (expected_powers.size() == 0)
                    report_mismatch($sformatf("power_result %h with no request pending",
                                              power_result));
                else if (power_result !== expected_powers[0])
                    report_mismatch($sformatf("power_result %h, expected %h",
                                              power_result, expected_powers[0]));
                if (expected_powers.size() != 0)
                    void'(expected_powers.pop_front());
            end
            if (in_valid && !in_stall)
                expected_powers.push_back(predict_power(base, exponent, modulus_shadow));
            backlog <= expected_powers.size();
        end
    end

endmodule

// ----- dv/modular_exponentiation_tb.sv -----
`timescale 1ns / 1ps

module modular_exponentiation_tb;
    import mexp_pkg::*;

    localparam int CYCLE_LIMIT  = 4000000;
    localparam int SETTLE_TAIL  = 16;
    localparam int PHASE_ITEMS  = 33;
    localparam int RANDOM_PHASES = 8;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [FIELD_BITS-1:0] base;
    logic [FIELD_BITS-1:0] exponent;
    logic                  out_valid;
    logic                  out_stall;
    logic [FIELD_BITS-1:0] power_result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [FIELD_BITS-1:0] modulus;

    int mismatches;
    int backlog;
    int results_seen;
    int cycle_count;
    int requests_sent;
    int modulus_writes;
    bit calm;

    modular_exponentiation uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .base        (base),
        .exponent    (exponent),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .power_result(power_result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .modulus     (modulus)
    );

    power_checker power_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .base        (base),
        .exponent    (exponent),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .power_result(power_result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .modulus     (modulus),
        .mismatches  (mismatches),
        .backlog     (backlog),
        .results_seen(results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, backlog);
            $display("FAILURE");
            $finish;
        end
    end

    // receiver back-pressure in bursts; none once calm
    initial
    begin
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
        end
    end

    task automatic idle_input(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // valid stays high across back-to-back requests, save for random idle gaps before calm
    task automatic send_request(input logic [FIELD_BITS-1:0] b, input logic [FIELD_BITS-1:0] e);
        if (!calm && $urandom_range(0, 3) == 0)
            idle_input($urandom_range(1, 9));
        in_valid <= 1'b1;
        base     <= b;
        exponent <= e;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        requests_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (backlog != 0)
            @(posedge clk);
        repeat (SETTLE_TAIL) @(posedge clk);
    endtask

    task automatic write_modulus(input logic [FIELD_BITS-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        modulus   <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        modulus_writes++;
    endtask

    task automatic send_random(input logic [FIELD_BITS-1:0] m);
        logic [FIELD_BITS-1:0] b;
        logic [FIELD_BITS-1:0] e;
        int pick;
        b    = $urandom();
        e    = $urandom();
        pick = $urandom_range(0, 19);
        if (pick < 2)
            e = '0;
        else if (pick < 5)
            e = $urandom_range(1, 64);
        else if (pick < 7)
            b = $urandom_range(0, 3);
        else if (pick < 9)
            b = m + $urandom_range(0, 3);
        else if (pick == 9)
            e = '1;
        send_request(b, e);
    endtask

    initial
    begin
        logic [FIELD_BITS-1:0] phase_modulus;
        requests_sent  = 0;
        modulus_writes = 0;
        calm           = 1'b0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        base      <= '0;
        exponent  <= '0;
        cfg_valid <= 1'b0;
        modulus   <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // modulus still at its reset value of one
        send_request(32'd5, 32'd0);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);

        write_modulus(32'd23);
        send_request(32'd0, 32'd0);
        send_request(32'd0, 32'd9);
        send_request(32'd2, 32'd11);
        send_request(32'd23, 32'd5);
        send_request(32'd24, 32'd2);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'd1, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, 32'd1);
        send_request(32'd7, 32'h8000_0000);
        send_request(32'd5, 32'd22);

        // no reduction: wraps at the operand width
        write_modulus(32'd0);
        send_request(32'd3, 32'd0);
        send_request(32'hFFFF_FFFF, 32'd2);
        send_request(32'd3, 32'hFFFF_FFFF);
        send_request(32'd2, 32'd32);
        send_request(32'd2, 32'd31);
        send_request(32'd0, 32'd1);

        write_modulus(32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, 32'd3);
        send_request(32'hFFFF_FFFE, 32'd2);

        write_modulus(32'd1);
        send_request(32'd9, 32'd1);
        send_request(32'd9, 32'd0);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       phase_modulus = 32'hFFFF_FFFB;
                1:       phase_modulus = $urandom() | 32'd1;
                2:       phase_modulus = $urandom_range(2, 500);
                3:       phase_modulus = 32'd0;
                4:       phase_modulus = 32'd1;
                5:       phase_modulus = 32'hFFFF_FFFF;
                6:       phase_modulus = $urandom();
                default: phase_modulus = $urandom_range(2, 32'hFFFF);
            endcase
            calm = (phase == RANDOM_PHASES - 1);
            write_modulus(phase_modulus);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // one mid-phase hold-off until every result is back
                if (phase == 2 && n == PHASE_ITEMS / 2)
                    drain_results();
                send_random(phase_modulus);
            end
        end

        drain_results();
        repeat (50) @(posedge clk);
        $display("Ran %0d requests (%0d results) across %0d modulus writes in %0d cycles,",
                 requests_sent, results_seen, modulus_writes, cycle_count);
        $display("covering zero exponents, moduli of 0, 1 and all ones, and unreduced bases.");
        if (mismatches == 0 && backlog == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/mexp_pkg.sv
rtl/core/mexp_mul.sv
rtl/core/mexp_seq.sv
rtl/core/modular_exponentiation.sv
rtl/core/mexp_check.sv
dv/power_checker.sv
dv/modular_exponentiation_tb.sv
